[rtl/core/gpm_pkg.sv]
`timescale 1ns / 1ps
package gpm_pkg;
	localparam int MAX_ELEMENTS_DEF = 32;

	typedef enum logic [1:0] {
		KIND_LITERAL = 2'd0,
		KIND_ANY     = 2'd1,
		KIND_STAR    = 2'd2,
		KIND_CLASS   = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_UNCLOSED = 2'd1,
		ST_FULL     = 2'd2
	} status_t;

	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_QUEST = 8'h3F;
	localparam logic [7:0] CH_LBRK  = 8'h5B;
	localparam logic [7:0] CH_RBRK  = 8'h5D;
	localparam logic [7:0] CH_CARET = 8'h5E;
	localparam logic [7:0] CH_DASH  = 8'h2D;

	typedef struct packed {
		logic       req_type;
		logic [7:0] char_byte;
		logic       is_last;
		logic       no_byte;
	} in_item_t;

	typedef struct packed {
		logic       matched;
		logic [1:0] status;
	} out_item_t;
endpackage

[rtl/core/glob_pattern_matcher_unit.sv]
`timescale 1ns / 1ps
// Glob matcher. A name byte is a class map read, then a set update in S_NREAD; a final
// name item then presents its result from S_OUT. A pattern byte passes S_P0 and S_P1, a
// class range adds a map read-modify-write per byte value of the range, and each new
// pattern first clears the 256-entry class map. A name item that ends an unfinished
// pattern first runs the pattern finish steps plus a map read for the waiting name byte.
// Reset is asynchronous: the empty pattern is loaded and the block is idle.
module glob_pattern_matcher_unit #(
	parameter int MAX_ELEMENTS = gpm_pkg::MAX_ELEMENTS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  gpm_pkg::in_item_t  in_data,
	output logic               out_valid,
	input  logic               out_stall,
	output gpm_pkg::out_item_t out_data
);
	import gpm_pkg::*;

	localparam int NP = MAX_ELEMENTS + 1;
	localparam int CW = $clog2(MAX_ELEMENTS + 1);
	localparam int IW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;

	typedef enum logic [8:0] {
		S_IDLE  = 9'b000000001,
		S_CLEAR = 9'b000000010,
		S_RANGE = 9'b000000100,
		S_NREAD = 9'b000001000,
		S_OUT   = 9'b000010000,
		S_P0    = 9'b000100000,
		S_P1    = 9'b001000000,
		S_P2    = 9'b010000000,
		S_P3    = 9'b100000000
	} state_t;
	// loader phases of the class parser: done, out, open, body, one, dash.
	typedef enum logic [5:0] {
		PH_DONE = 6'b000001,
		PH_OUT  = 6'b000010,
		PH_OPEN = 6'b000100,
		PH_BODY = 6'b001000,
		PH_ONE  = 6'b010000,
		PH_DASH = 6'b100000
	} phase_t;

	state_t state_q;
	phase_t phase_q;
	logic [1:0]  kind_q [MAX_ELEMENTS];
	logic [7:0]  lit_q  [MAX_ELEMENTS];
	logic [MAX_ELEMENTS-1:0] inv_q;
	logic [CW-1:0] count_q;
	logic [7:0]  p0_q;
	status_t     status_q;
	logic [NP-1:0] act_q;
	logic [MAX_ELEMENTS-1:0] map_mem [256];
	logic [MAX_ELEMENTS-1:0] map_rd_q;
	logic [8:0]  ptr_q;
	logic [7:0]  hi_q;
	logic        rng_last_q;
	logic [1:0]  rng_extra_q;
	in_item_t    held_q;
	logic        held_v_q;
	logic        name_pend_q;
	logic        nlast_q, nnob_q;
	logic [7:0]  nch_q;
	out_item_t   out_q;
	logic        out_v_q;

	// Star closure over the element table, a chain of single-bit steps.
	function automatic logic [NP-1:0] closure(input logic [NP-1:0] s,
		input logic [CW-1:0] n, input logic [MAX_ELEMENTS-1:0] star);
		logic [NP-1:0] r;
		r = s;
		for (int i = 0; i < MAX_ELEMENTS; i++)
			if (i < int'(n) && r[i] && star[i]) r[i+1] = 1'b1;
		return r;
	endfunction

	logic [MAX_ELEMENTS-1:0] star_v, any_v, cls_v, lit_hit;
	always_comb begin
		for (int i = 0; i < MAX_ELEMENTS; i++) begin
			star_v[i]  = kind_q[i] == KIND_STAR;
			any_v[i]   = kind_q[i] == KIND_ANY;
			cls_v[i]   = kind_q[i] == KIND_CLASS;
			lit_hit[i] = kind_q[i] == KIND_LITERAL && lit_q[i] == nch_q;
		end
	end

	logic [NP-1:0] start_set, adv_set;
	always_comb begin
		start_set = closure({{(NP-1){1'b0}}, 1'b1}, count_q, star_v);
		adv_set = '0;
		for (int i = 0; i < MAX_ELEMENTS; i++) begin
			if (i < int'(count_q) && act_q[i]) begin
				if (star_v[i]) adv_set[i] = 1'b1;
				if (any_v[i] || lit_hit[i] ||
					(cls_v[i] && (map_rd_q[i] != inv_q[i]))) adv_set[i+1] = 1'b1;
			end
		end
		adv_set = closure(adv_set, count_q, star_v);
	end

	// Accept only while idle with nothing held back and no stalled result in the output slot.
	assign in_stall = !(state_q == S_IDLE) || held_v_q || name_pend_q ||
		(out_v_q && out_stall);
	wire acc = in_valid && !in_stall;
	assign out_valid = out_v_q;
	assign out_data = out_q;

	wire full = count_q >= CW'(MAX_ELEMENTS);
	wire [IW-1:0] cur = IW'(count_q - CW'(1));
	wire can_map = status_q != ST_FULL && count_q != '0;

	// Class map memory: one write and one registered read a cycle.
	logic map_we;
	logic [7:0] map_wa, map_ra;
	logic [MAX_ELEMENTS-1:0] map_wd;
	always_ff @(posedge clk) begin
		if (map_we) map_mem[map_wa] <= map_wd;
		map_rd_q <= map_mem[map_ra];
	end

	// Range fill is read then write on alternate cycles: rng_last_q marks write.
	always_comb begin
		map_we = 1'b0; map_wa = ptr_q[7:0]; map_wd = '0; map_ra = ptr_q[7:0];
		if (state_q == S_CLEAR) map_we = 1'b1;
		if (state_q == S_RANGE && rng_last_q) begin
			map_we = 1'b1;
			map_wd = map_rd_q;
			map_wd[cur] = 1'b1;
		end
		if (acc && in_data.req_type) map_ra = in_data.char_byte;
		if (state_q == S_IDLE && name_pend_q) map_ra = nch_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE; phase_q <= PH_DONE; count_q <= '0;
			status_q <= ST_OK; act_q <= NP'(1); out_v_q <= 1'b0;
			held_v_q <= 1'b0; rng_last_q <= 1'b0; rng_extra_q <= 2'd0;
			ptr_q <= '0; name_pend_q <= 1'b0;
		end else begin
			if (out_v_q && !out_stall) out_v_q <= 1'b0;
			unique case (state_q)
				S_IDLE: if (held_v_q) begin
					held_v_q <= 1'b0;
					state_q <= S_P0;
				end else if (name_pend_q) begin
					// The pattern is finished; read the map for the waiting name byte.
					name_pend_q <= 1'b0;
					state_q <= S_NREAD;
				end else if (acc) begin
					if (!in_data.req_type && phase_q == PH_DONE) begin
						count_q <= '0; status_q <= ST_OK; phase_q <= PH_OUT;
						ptr_q <= '0; held_q <= in_data; held_v_q <= 1'b1;
						state_q <= S_CLEAR;
					end else if (!in_data.req_type) begin
						held_q <= in_data; state_q <= S_P0;
					end else begin
						nch_q <= in_data.char_byte; nlast_q <= in_data.is_last;
						nnob_q <= in_data.no_byte;
						state_q <= S_NREAD;
						if (phase_q != PH_DONE) begin
							held_q <= '{req_type: 1'b0, char_byte: 8'h00, is_last: 1'b1,
								no_byte: 1'b1};
							name_pend_q <= 1'b1;
							state_q <= S_P0;
						end
					end
				end
				S_CLEAR: begin
					ptr_q <= ptr_q + 9'd1;
					if (ptr_q[7:0] == 8'hFF) state_q <= S_IDLE;
				end
				S_RANGE: begin
					// rng_last_q=0: read issued; =1: write back and step.
					rng_last_q <= !rng_last_q;
					if (rng_last_q) begin
						if (ptr_q[7:0] >= hi_q) begin
							if (rng_extra_q == 2'd2) begin
								ptr_q <= {1'b0, CH_DASH}; hi_q <= CH_DASH;
								rng_extra_q <= 2'd0;
							end else state_q <= S_P1;
						end else ptr_q <= ptr_q + 9'd1;
					end
				end
				S_P0: begin
					// Pattern byte, then any class range fill, then finishing in S_P1.
					state_q <= S_P1;
					if (!held_q.no_byte) begin
						unique case (phase_q)
							PH_OPEN: if (held_q.char_byte == CH_CARET) begin
								if (can_map) inv_q[cur] <= 1'b1;
								phase_q <= PH_BODY;
							end else if (held_q.char_byte == CH_RBRK) phase_q <= PH_OUT;
							else begin p0_q <= held_q.char_byte; phase_q <= PH_ONE; end
							PH_BODY: if (held_q.char_byte == CH_RBRK) phase_q <= PH_OUT;
							else begin p0_q <= held_q.char_byte; phase_q <= PH_ONE; end
							PH_ONE: if (held_q.char_byte == CH_DASH) phase_q <= PH_DASH;
							else begin
								if (can_map) begin
									ptr_q <= {1'b0, p0_q}; hi_q <= p0_q; rng_last_q <= 1'b0;
									rng_extra_q <= 2'd0; state_q <= S_RANGE;
								end
								held_q.no_byte <= 1'b1;
								if (held_q.char_byte == CH_RBRK) phase_q <= PH_OUT;
								else begin p0_q <= held_q.char_byte; phase_q <= PH_ONE; end
							end
							PH_DASH: begin
								phase_q <= PH_BODY;
								if (can_map && p0_q <= held_q.char_byte) begin
									ptr_q <= {1'b0, p0_q}; hi_q <= held_q.char_byte;
									rng_last_q <= 1'b0; rng_extra_q <= 2'd0;
									state_q <= S_RANGE;
								end
							end
							default: begin
								if (full) begin
									if (status_q == ST_OK) status_q <= ST_FULL;
								end else begin
									count_q <= count_q + CW'(1);
									inv_q[count_q[IW-1:0]] <= 1'b0;
									lit_q[count_q[IW-1:0]] <= held_q.char_byte;
									kind_q[count_q[IW-1:0]] <=
										held_q.char_byte == CH_STAR  ? KIND_STAR :
										held_q.char_byte == CH_QUEST ? KIND_ANY :
										held_q.char_byte == CH_LBRK  ? KIND_CLASS : KIND_LITERAL;
								end
								if (held_q.char_byte == CH_LBRK) phase_q <= PH_OPEN;
							end
						endcase
					end
				end
				S_P1: begin
					state_q <= S_IDLE;
					if (held_q.is_last) begin
						if (phase_q == PH_ONE || phase_q == PH_DASH) begin
							// Pending class bytes are added, then the pattern ends unclosed.
							ptr_q <= {1'b0, p0_q}; hi_q <= p0_q; rng_last_q <= 1'b0;
							rng_extra_q <= (phase_q == PH_DASH) ? 2'd2 : 2'd0;
							state_q <= can_map ? S_RANGE : S_P1;
							phase_q <= PH_OPEN;
						end else begin
							if (phase_q == PH_OPEN || phase_q == PH_BODY)
								if (status_q == ST_OK) status_q <= ST_UNCLOSED;
							phase_q <= PH_DONE;
							act_q <= start_set;
						end
					end
				end
				S_NREAD: begin
					state_q <= nlast_q ? S_OUT : S_IDLE;
					if (!nnob_q) act_q <= adv_set;
				end
				S_OUT: begin
					out_q.matched <= status_q == ST_OK && act_q[count_q];
					out_q.status <= status_q;
					out_v_q <= 1'b1;
					act_q <= start_set;
					state_q <= S_IDLE;
				end
				S_P2, S_P3: state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	ap_out_held: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q && out_stall |=> out_v_q && $stable(out_q))
		else $error("result item lost under stall");
	ap_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_CLEAR |-> in_stall)
		else $error("input accepted during map clear");
	ap_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_ELEMENTS))
		else $error("element count beyond capacity");
endmodule

[verif/glob_match_checker.sv]
`timescale 1ns / 1ps
module glob_match_checker #(
	parameter int MAX_ELEMENTS = gpm_pkg::MAX_ELEMENTS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_stall,
	input  gpm_pkg::in_item_t  in_data,
	input  logic               out_valid,
	input  logic               out_stall,
	input  gpm_pkg::out_item_t out_data,
	output int                 fail_count,
	output int                 pending_verdicts,
	output int                 verdicts_seen
);
	import gpm_pkg::*;

	// Loader phases of the pattern compiler.
	typedef enum int {LD_DONE, LD_OUT, LD_OPEN, LD_BODY, LD_ONE, LD_DASH} load_phase_t;

	kind_t        elem_kind [64];
	logic [7:0]   elem_lit [64];
	logic         elem_inv [64];
	logic [63:0]  member_map [256];
	logic [63:0]  live_set;
	int           elem_cnt;
	load_phase_t  phase;
	logic [7:0]   held_byte;
	status_t      pat_status;
	out_item_t    verdict_q [$];

	// Adds the star closure to a set of positions.
	function automatic logic [63:0] close_stars(logic [63:0] s);
		for (int i = 0; i < elem_cnt; i++)
			if (s[i] && elem_kind[i] == KIND_STAR) s[i + 1] = 1'b1;
		return s;
	endfunction

	task automatic push_elem(kind_t k, logic [7:0] lit);
		if (elem_cnt < MAX_ELEMENTS && elem_cnt < 63) begin
			elem_kind[elem_cnt] = k;
			elem_lit[elem_cnt] = lit;
			elem_inv[elem_cnt] = 1'b0;
			elem_cnt++;
		end else if (pat_status == ST_OK) begin
			pat_status = ST_FULL;
		end
	endtask

	task automatic mark_range(int lo, int hi);
		if (pat_status == ST_FULL || elem_cnt == 0) return;
		for (int v = lo; v <= hi && v < 256; v++) member_map[v][elem_cnt - 1] = 1'b1;
	endtask

	task automatic class_byte(logic [7:0] c);
		if (c == CH_RBRK) begin
			phase = LD_OUT;
		end else begin
			held_byte = c;
			phase = LD_ONE;
		end
	endtask

	task automatic compile_byte(logic [7:0] c);
		if (phase == LD_DONE) phase = LD_OUT;
		case (phase)
			LD_OUT: begin
				if (c == CH_STAR) push_elem(KIND_STAR, 8'd0);
				else if (c == CH_QUEST) push_elem(KIND_ANY, 8'd0);
				else if (c == CH_LBRK) begin
					push_elem(KIND_CLASS, 8'd0);
					phase = LD_OPEN;
				end else push_elem(KIND_LITERAL, c);
			end
			LD_OPEN: begin
				if (c == CH_CARET) begin
					if (pat_status != ST_FULL && elem_cnt > 0) elem_inv[elem_cnt - 1] = 1'b1;
					phase = LD_BODY;
				end else class_byte(c);
			end
			LD_BODY: class_byte(c);
			LD_ONE: begin
				if (c == CH_DASH) phase = LD_DASH;
				else begin
					mark_range(held_byte, held_byte);
					class_byte(c);
				end
			end
			default: begin
				mark_range(held_byte, c);
				held_byte = 8'd0;
				phase = LD_BODY;
			end
		endcase
	endtask

	task automatic close_pattern();
		if (phase >= LD_OPEN) begin
			if (pat_status != ST_FULL && elem_cnt > 0) begin
				if (phase == LD_ONE || phase == LD_DASH) mark_range(held_byte, held_byte);
				if (phase == LD_DASH) mark_range(CH_DASH, CH_DASH);
			end
			if (pat_status == ST_OK) pat_status = ST_UNCLOSED;
		end
		held_byte = 8'd0;
		phase = LD_DONE;
		live_set = close_stars(64'd1);
	endtask

	task automatic step_name(logic [7:0] c);
		logic [63:0] nxt;
		logic take;
		nxt = '0;
		for (int i = 0; i < elem_cnt; i++) begin
			if (!live_set[i]) continue;
			take = 1'b0;
			case (elem_kind[i])
				KIND_STAR: nxt[i] = 1'b1;
				KIND_ANY: take = 1'b1;
				KIND_CLASS: take = member_map[c][i] ^ elem_inv[i];
				default: take = (elem_lit[i] == c);
			endcase
			if (take) nxt[i + 1] = 1'b1;
		end
		live_set = close_stars(nxt);
	endtask

	task automatic predict_item(in_item_t it);
		out_item_t v;
		if (!it.req_type) begin
			if (phase == LD_DONE) begin
				elem_cnt = 0;
				foreach (member_map[i]) member_map[i] = '0;
				pat_status = ST_OK;
				held_byte = 8'd0;
				phase = LD_OUT;
			end
			if (!it.no_byte) compile_byte(it.char_byte);
			if (it.is_last) close_pattern();
		end else begin
			if (phase != LD_DONE) close_pattern();
			if (!it.no_byte) step_name(it.char_byte);
			if (it.is_last) begin
				v.status = pat_status;
				v.matched = (pat_status == ST_OK) && live_set[elem_cnt];
				verdict_q.push_back(v);
				live_set = close_stars(64'd1);
			end
		end
	endtask

	// Watch both channels: predict on input, compare on output.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			foreach (member_map[i]) member_map[i] = '0;
			elem_cnt = 0;
			phase = LD_DONE;
			held_byte = 8'd0;
			pat_status = ST_OK;
			live_set = 64'd1;
			verdict_q.delete();
			fail_count = 0;
			verdicts_seen = 0;
		end else begin
			if (out_valid && !out_stall) begin
				verdicts_seen++;
				if (verdict_q.size() == 0) begin
					$display("%0t: unexpected result %p", $time, out_data);
					fail_count++;
				end else begin
					out_item_t e;
					e = verdict_q.pop_front();
					if (e.matched !== out_data.matched || e.status !== out_data.status) begin
						$display("%0t: mismatch expected matched=%0b status=%0d actual matched=%0b status=%0d",
							$time, e.matched, e.status, out_data.matched, out_data.status);
						fail_count++;
					end
				end
			end
			if (in_valid && !in_stall) predict_item(in_data);
		end
		pending_verdicts = verdict_q.size();
	end
endmodule

[verif/glob_pattern_matcher_unit_tb.sv]
`timescale 1ns / 1ps
module glob_pattern_matcher_unit_tb;
	import gpm_pkg::*;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      in_valid = 1'b0;
	logic      in_stall;
	in_item_t  in_data = '0;
	logic      out_valid;
	logic      out_stall = 1'b0;
	out_item_t out_data;
	int        fail_count;
	int        pending_verdicts;
	int        verdicts_seen;
	int        hold_cycles = 0;
	int        hold_reqs = 0;
	int        hold_done = 0;
	int        names_sent = 0;

	glob_pattern_matcher_unit uut (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.in_data(in_data), .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
	);

	glob_match_checker chk (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.in_data(in_data), .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.fail_count(fail_count), .pending_verdicts(pending_verdicts),
		.verdicts_seen(verdicts_seen)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Receiver stall pattern; a requested hold-off forces a long stall.
	always @(negedge clk) begin
		if (hold_cycles > 0) begin
			out_stall <= 1'b1;
			hold_cycles <= hold_cycles - 1;
		end else if (hold_done != hold_reqs) begin
			hold_done <= hold_reqs;
			hold_cycles <= 300;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(0, 3) == 0);
		end
	end

	// Offers one item and waits for it to be accepted, at times with a random gap after.
	task automatic send_item(logic rt, logic [7:0] c, logic last, logic nob);
		in_data <= '{req_type: rt, char_byte: c, is_last: last, no_byte: nob};
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
		if ($urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
		if (rt && last) names_sent++;
	endtask

	task automatic send_text(logic rt, string s);
		if (s.len() == 0) send_item(rt, 8'($urandom), 1'b1, 1'b1);
		for (int i = 0; i < s.len(); i++) send_item(rt, s[i], i == s.len() - 1, 1'b0);
	endtask

	function automatic logic [7:0] pick_byte();
		case ($urandom_range(0, 9))
			0: return CH_STAR;
			1: return CH_QUEST;
			2: return CH_LBRK;
			3: return CH_RBRK;
			4: return CH_CARET;
			5: return CH_DASH;
			6: return 8'($urandom);
			default: return 8'("a" + $urandom_range(0, 3));
		endcase
	endfunction

	// A mostly well formed random pattern.
	function automatic string make_pattern();
		string s;
		int n;
		s = "";
		n = ($urandom_range(0, 30) == 0) ? $urandom_range(30, 36) : $urandom_range(0, 6);
		for (int i = 0; i < n; i++) begin
			case ($urandom_range(0, 6))
				0: s = {s, "*"};
				1: s = {s, "?"};
				2: s = {s, "[", ($urandom_range(0, 2) == 0) ? string'("^") : string'(""),
					string'(8'("a" + $urandom_range(0, 3))), "-",
					string'(8'("a" + $urandom_range(0, 3))), "]"};
				3: s = {s, string'(pick_byte())};
				default: s = {s, string'(8'("a" + $urandom_range(0, 3)))};
			endcase
		end
		return s;
	endfunction

	function automatic string make_name();
		string s;
		s = "";
		repeat ($urandom_range(0, 6)) s = {s, string'(pick_byte())};
		return s;
	endfunction

	initial begin
		int sent;
		bit pressed;
		pressed = 1'b0;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		// Directed: empty pattern, extremes, classes, errors.
		send_text(1'b1, "");
		send_text(1'b0, "a*[]?");
		send_item(1'b1, 8'h00, 1'b0, 1'b1);
		send_item(1'b1, 8'hFF, 1'b1, 1'b0);
		send_text(1'b0, "[^]*");
		send_text(1'b1, "\377");
		send_text(1'b0, "[a-]");
		send_text(1'b1, "a");
		send_text(1'b0, "[z-a]x");
		send_text(1'b1, "x");
		send_item(1'b0, CH_LBRK, 1'b0, 1'b0);
		send_text(1'b1, "q");
		send_text(1'b0, "*********************************");
		send_text(1'b1, "ab");
		send_item(1'b0, 8'hFF, 1'b0, 1'b0);
		send_item(1'b0, 8'h00, 1'b1, 1'b1);
		send_item(1'b1, 8'hFF, 1'b1, 1'b0);
		sent = 65;
		// Random: patterns followed by several names each.
		while (sent < 850) begin
			string p;
			p = make_pattern();
			send_text(1'b0, p);
			sent += (p.len() == 0) ? 1 : p.len();
			repeat ($urandom_range(1, 5)) begin
				string n;
				n = make_name();
				send_text(1'b1, n);
				sent += (n.len() == 0) ? 1 : n.len();
			end
			if (!pressed && sent > 400) begin
				pressed = 1'b1;
				// Long receiver hold-off while names keep coming.
				hold_reqs++;
				repeat (20) send_text(1'b1, "ab");
				sent += 40;
				// Sender pause until all expected results are out.
				in_valid <= 1'b0;
				while (pending_verdicts != 0) @(negedge clk);
			end
		end
		in_valid <= 1'b0;
		while (pending_verdicts != 0) @(negedge clk);
		repeat (20) @(negedge clk);
		$display("Sent %0d names, checked %0d results, errors and edge classes included.",
			names_sent, verdicts_seen);
		if (fail_count == 0) $display("Verification passed");
		else $display("Verification failed");
		$finish;
	end

	initial begin
		#20ms;
		$display("Verification failed");
		$finish;
	end
endmodule
